// ===== src/edgpsf_pkg.sv =====
// Shared types, constants and elaboration-time functions for the elliptical
// double-Gaussian PSF core. Depends on nothing; every other file in src uses it.
package edgpsf_pkg;

    // Fixed field widths and fixed-point constants.
    localparam int unsigned CoordWidth   = 16;
    localparam int unsigned ExpRangeLog2 = 4;
    localparam int unsigned RomWidth     = 31;
    localparam int unsigned GaussWidth   = 31;
    localparam int unsigned PrefWidth    = 31;
    localparam int unsigned UMidWidth    = 20;

    localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;
    localparam logic [63:0] Ln2Q32      = 64'd2977044472;
    localparam logic [16:0] WeightOne   = 17'd65536;

    // Register indexes on the write port.
    localparam logic [2:0] CfgCosAngle       = 3'd0;
    localparam logic [2:0] CfgSinAngle       = 3'd1;
    localparam logic [2:0] CfgAxisRatio      = 3'd2;
    localparam logic [2:0] CfgInvAxisRatio   = 3'd3;
    localparam logic [2:0] CfgCoreWeight     = 3'd4;
    localparam logic [2:0] CfgNarrowPrec     = 3'd5;
    localparam logic [2:0] CfgWidePrec       = 3'd6;
    localparam logic [2:0] CfgEdgeRadiusSq   = 3'd7;

    // Register reset values.
    localparam logic signed [15:0] RstCosAngle     = 16'sd16384;
    localparam logic signed [15:0] RstSinAngle     = 16'sd0;
    localparam logic [15:0]        RstAxisRatio    = 16'd4096;
    localparam logic [15:0]        RstInvAxisRatio = 16'd4096;
    localparam logic [16:0]        RstCoreWeight   = 17'd32768;
    localparam logic [23:0]        RstNarrowPrec   = 24'd65536;
    localparam logic [23:0]        RstWidePrec     = 24'd65536;
    localparam logic [31:0]        RstEdgeRadiusSq = 32'd1638400;

    typedef struct packed {
        logic signed [CoordWidth-1:0] offset_x;
        logic signed [CoordWidth-1:0] offset_y;
    } psf_in_t;

    typedef struct packed {
        logic [31:0] psf_value;
        logic        inside_edge;
    } psf_out_t;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic [15:0]        axis_ratio;
        logic [15:0]        inv_axis_ratio;
        logic [16:0]        core_weight;
        logic [23:0]        narrow_precision;
        logic [23:0]        wide_precision;
        logic [31:0]        edge_radius_sq;
    } psf_cfg_t;

    // Beat from the radius pipeline to the Gaussian pipeline.
    typedef struct packed {
        logic        valid;
        logic        in_edge;
        logic [31:0] rsq;
    } rad_beat_t;

    // Beat from the Gaussian pipeline to the mixing stages.
    typedef struct packed {
        logic                  valid;
        logic                  in_edge;
        logic [GaussWidth-1:0] gn;
        logic [GaussWidth-1:0] gw;
    } gauss_beat_t;

    // Division by the small Taylor indexes, used only while building the table.
    function automatic logic [63:0] div_small(input logic [63:0] v, input int unsigned d);
        logic [63:0] q;
        unique case (d)
            2:       q = v / 64'd2;
            3:       q = v / 64'd3;
            4:       q = v / 64'd4;
            5:       q = v / 64'd5;
            6:       q = v / 64'd6;
            7:       q = v / 64'd7;
            8:       q = v / 64'd8;
            9:       q = v / 64'd9;
            10:      q = v / 64'd10;
            11:      q = v / 64'd11;
            12:      q = v / 64'd12;
            13:      q = v / 64'd13;
            14:      q = v / 64'd14;
            15:      q = v / 64'd15;
            16:      q = v / 64'd16;
            default: q = v;
        endcase
        return q;
    endfunction

    // exp(-x) in Q1.30 for x in Q.32: ln2 range reduction then a Taylor series
    // to order 16 in Q.32. Evaluated at elaboration only.
    function automatic logic [RomWidth-1:0] exp_neg_q30(input logic [63:0] x);
        logic [63:0]          n;
        logic [63:0]          r;
        logic [63:0]          term;
        logic [63:0]          pos;
        logic [63:0]          neg;
        logic [63:0]          res;
        logic [RomWidth-1:0]  val;
        int unsigned          i;
        n    = x / Ln2Q32;
        r    = x - n * Ln2Q32;
        term = 64'd1 << 32;
        pos  = term;
        neg  = '0;
        for (i = 1; i <= 16; i++)
        begin
            term = div_small((term * r) >> 32, i);
            if (i[0])
            begin
                neg = neg + term;
            end
            else
            begin
                pos = pos + term;
            end
        end
        res = pos - neg;
        if (n >= 64'd40)
        begin
            val = '0;
        end
        else
        begin
            res = res >> n;
            val = RomWidth'((res + 64'd2) >> 2);
        end
        return val;
    endfunction

endpackage

// ===== src/edgpsf_radius.sv =====
// Rotation and squared elliptical radius pipeline, five register stages.
// Depends on edgpsf_pkg for the input, configuration and beat types.
module edgpsf_radius
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  edgpsf_pkg::psf_in_t   item,
    input  edgpsf_pkg::psf_cfg_t  cfg,
    output edgpsf_pkg::rad_beat_t rad
);

    // Stage 1: the four rotation products.
    logic               v1_reg, v1_next;
    logic signed [31:0] xc_reg, xc_next, ys_reg, ys_next, yc_reg, yc_next, xs_reg, xs_next;
    // Stage 2: rounded magnitudes of the rotated coordinates.
    logic               v2_reg, v2_next;
    logic [17:0]        mx_reg, mx_next, my_reg, my_next;
    // Stage 3: squares.
    logic               v3_reg, v3_next;
    logic [35:0]        sqx_reg, sqx_next, sqy_reg, sqy_next;
    // Stage 4: squares scaled by the axis ratios.
    logic               v4_reg, v4_next;
    logic [51:0]        tx_reg, tx_next, ty_reg, ty_next;
    // Stage 5: squared radius and edge test.
    logic               v5_reg, v5_next;
    logic               in5_reg, in5_next;
    logic [31:0]        rsq_reg, rsq_next;

    logic signed [32:0] xr, yr;
    logic [32:0]        ax, ay;
    logic [33:0]        rx, ry;
    logic [52:0]        sum;
    logic [40:0]        rsq_full;

    always_comb
    begin
        v1_next = in_valid;
        xc_next = 32'(item.offset_x) * 32'(cfg.cos_angle);
        ys_next = 32'(item.offset_y) * 32'(cfg.sin_angle);
        yc_next = 32'(item.offset_y) * 32'(cfg.cos_angle);
        xs_next = 32'(item.offset_x) * 32'(cfg.sin_angle);

        // The magnitudes never exceed 2^31, so the rounded values fit 18 bits.
        xr      = 33'(xc_reg) + 33'(ys_reg);
        yr      = 33'(yc_reg) - 33'(xs_reg);
        ax      = xr[32] ? 33'(-xr) : 33'(xr);
        ay      = yr[32] ? 33'(-yr) : 33'(yr);
        rx      = 34'(ax) + 34'd8192;
        ry      = 34'(ay) + 34'd8192;
        v2_next = v1_reg;
        mx_next = rx[31:14];
        my_next = ry[31:14];

        v3_next  = v2_reg;
        sqx_next = 36'(mx_reg) * 36'(mx_reg);
        sqy_next = 36'(my_reg) * 36'(my_reg);

        v4_next = v3_reg;
        tx_next = 52'(sqx_reg) * 52'(cfg.axis_ratio);
        ty_next = 52'(sqy_reg) * 52'(cfg.inv_axis_ratio);

        // The sum fits its 53 bits for 16-bit offsets; rsq keeps only the low 32 bits.
        sum      = 53'(tx_reg) + 53'(ty_reg) + 53'd2048;
        rsq_full = sum[52:12];
        v5_next  = v4_reg;
        in5_next = rsq_full < 41'(cfg.edge_radius_sq);
        rsq_next = rsq_full[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
            v5_reg <= v5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xc_reg  <= xc_next;
        ys_reg  <= ys_next;
        yc_reg  <= yc_next;
        xs_reg  <= xs_next;
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        in5_reg <= in5_next;
        rsq_reg <= rsq_next;
    end

    assign rad.valid   = v5_reg;
    assign rad.in_edge = in5_reg;
    assign rad.rsq     = rsq_reg;

endmodule

// ===== src/edgpsf_exp_rom.sv =====
// Two-port exp(-u) table with registered reads; contents fixed at elaboration.
// Depends on edgpsf_pkg for the table entry function and widths.
module edgpsf_exp_rom
#(
    parameter  int EXP_TABLE_DEPTH = 1024,
    localparam int AddrWidth       = $clog2(EXP_TABLE_DEPTH)
)
(
    input  logic                             clk,
    input  logic [AddrWidth-1:0]             addr_a,
    input  logic [AddrWidth-1:0]             addr_b,
    output logic [edgpsf_pkg::RomWidth-1:0]  data_a,
    output logic [edgpsf_pkg::RomWidth-1:0]  data_b
);

    logic [edgpsf_pkg::RomWidth-1:0] rom_w [EXP_TABLE_DEPTH];
    logic [edgpsf_pkg::RomWidth-1:0] data_a_reg, data_a_next, data_b_reg, data_b_next;

    // Entry k holds exp(-k * 2^ExpRangeLog2 / depth).
    for (genvar k = 0; k < EXP_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [63:0] Arg =
            (64'(k) << (32 + edgpsf_pkg::ExpRangeLog2)) / EXP_TABLE_DEPTH;
        localparam logic [edgpsf_pkg::RomWidth-1:0] Entry = edgpsf_pkg::exp_neg_q30(Arg);
        assign rom_w[k] = Entry;
    end

    always_comb
    begin
        data_a_next = rom_w[addr_a];
        data_b_next = rom_w[addr_b];
    end

    always_ff @(posedge clk)
    begin
        data_a_reg <= data_a_next;
        data_b_reg <= data_b_next;
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ===== src/edgpsf_gauss.sv =====
// Gaussian term pipeline: exponent argument, table address, table read and
// prefactor scaling for both Gaussians. Depends on edgpsf_pkg and edgpsf_exp_rom.
module edgpsf_gauss
#(
    parameter int EXP_TABLE_DEPTH = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  edgpsf_pkg::psf_cfg_t    cfg,
    input  edgpsf_pkg::rad_beat_t   rad,
    output edgpsf_pkg::gauss_beat_t gauss
);

    localparam int unsigned AddrWidth     = $clog2(EXP_TABLE_DEPTH);
    localparam int unsigned DepthBits     = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int unsigned AddrProdWidth = edgpsf_pkg::UMidWidth + DepthBits;
    localparam logic [AddrProdWidth-1:0] DepthC = AddrProdWidth'(EXP_TABLE_DEPTH);

    localparam int unsigned GW = edgpsf_pkg::GaussWidth;
    localparam int unsigned PW = edgpsf_pkg::PrefWidth;
    localparam int unsigned RW = edgpsf_pkg::RomWidth;
    localparam int unsigned MW = edgpsf_pkg::UMidWidth;

    // Prefactors precision / 2pi in Q.24, following the registers.
    logic [PW-1:0]        pfn_reg, pfn_next, pfw_reg, pfw_next;
    // Stage 1: exponent argument, split into table bits and a range flag.
    logic                 v1_reg, v1_next, in1_reg, in1_next;
    logic [MW-1:0]        midn_reg, midn_next, midw_reg, midw_next;
    logic                 farn1_reg, farn1_next, farw1_reg, farw1_next;
    // Stage 2: table addresses.
    logic                 v2_reg, v2_next, in2_reg, in2_next;
    logic [AddrWidth-1:0] addrn_reg, addrn_next, addrw_reg, addrw_next;
    logic                 farn2_reg, farn2_next, farw2_reg, farw2_next;
    // Stage 3: table read in progress.
    logic                 v3_reg, v3_next, in3_reg, in3_next;
    logic                 farn3_reg, farn3_next, farw3_reg, farw3_next;
    // Stage 4: scaled Gaussian terms.
    logic                 v4_reg, v4_next, in4_reg, in4_next;
    logic [GW-1:0]        gn_reg, gn_next, gw_reg, gw_next;

    logic [55:0]              pfn_prod, pfw_prod;
    logic [55:0]              un_prod, uw_prod;
    logic [AddrProdWidth-1:0] an_prod, aw_prod;
    logic [RW-1:0]            en_data, ew_data;
    logic [61:0]              tn_prod, tw_prod;
    logic [62:0]              tn_round, tw_round;

    edgpsf_exp_rom #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_rom (
        .clk    (clk),
        .addr_a (addrn_reg),
        .addr_b (addrw_reg),
        .data_a (en_data),
        .data_b (ew_data)
    );

    always_comb
    begin
        pfn_prod = 56'(cfg.narrow_precision) * 56'(edgpsf_pkg::InvTwoPiQ32) + 56'd8388608;
        pfw_prod = 56'(cfg.wide_precision) * 56'(edgpsf_pkg::InvTwoPiQ32) + 56'd8388608;
        pfn_next = pfn_prod[54:24];
        pfw_next = pfw_prod[54:24];

        // u = (rsq * precision) / 2; only u below 2^36 lands in the table.
        un_prod    = 56'(rad.rsq) * 56'(cfg.narrow_precision);
        uw_prod    = 56'(rad.rsq) * 56'(cfg.wide_precision);
        v1_next    = rad.valid;
        in1_next   = rad.in_edge;
        midn_next  = un_prod[36:17];
        midw_next  = uw_prod[36:17];
        farn1_next = |un_prod[55:37];
        farw1_next = |uw_prod[55:37];

        an_prod    = AddrProdWidth'(midn_reg) * DepthC;
        aw_prod    = AddrProdWidth'(midw_reg) * DepthC;
        v2_next    = v1_reg;
        in2_next   = in1_reg;
        addrn_next = an_prod[MW +: AddrWidth];
        addrw_next = aw_prod[MW +: AddrWidth];
        farn2_next = farn1_reg;
        farw2_next = farw1_reg;

        v3_next    = v2_reg;
        in3_next   = in2_reg;
        farn3_next = farn2_reg;
        farw3_next = farw2_reg;

        tn_prod  = 62'(pfn_reg) * 62'(en_data);
        tw_prod  = 62'(pfw_reg) * 62'(ew_data);
        tn_round = 63'(tn_prod) + 63'd536870912;
        tw_round = 63'(tw_prod) + 63'd536870912;
        v4_next  = v3_reg;
        in4_next = in3_reg;
        gn_next  = farn3_reg ? '0 : tn_round[60:30];
        gw_next  = farw3_reg ? '0 : tw_round[60:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pfn_reg   <= pfn_next;
        pfw_reg   <= pfw_next;
        in1_reg   <= in1_next;
        midn_reg  <= midn_next;
        midw_reg  <= midw_next;
        farn1_reg <= farn1_next;
        farw1_reg <= farw1_next;
        in2_reg   <= in2_next;
        addrn_reg <= addrn_next;
        addrw_reg <= addrw_next;
        farn2_reg <= farn2_next;
        farw2_reg <= farw2_next;
        in3_reg   <= in3_next;
        farn3_reg <= farn3_next;
        farw3_reg <= farw3_next;
        in4_reg   <= in4_next;
        gn_reg    <= gn_next;
        gw_reg    <= gw_next;
    end

    assign gauss.valid   = v4_reg;
    assign gauss.in_edge = in4_reg;
    assign gauss.gn      = gn_reg;
    assign gauss.gw      = gw_reg;

endmodule

// ===== src/edgpsf_mix.sv =====
// Weighted mix of the two Gaussian terms, rounding, saturation and the result
// register. Depends on edgpsf_pkg for the beat, configuration and result types.
module edgpsf_mix
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  edgpsf_pkg::psf_cfg_t    cfg,
    input  edgpsf_pkg::gauss_beat_t gauss,
    output logic                    done,
    output edgpsf_pkg::psf_out_t    result
);

    // Weights follow the registers; a weight above one counts as one.
    logic [16:0]          w_reg, w_next, wc_reg, wc_next;
    logic                 v1_reg, v1_next, in1_reg, in1_next;
    logic [47:0]          pn_reg, pn_next, pw_reg, pw_next;
    logic                 done_reg, done_next;
    edgpsf_pkg::psf_out_t res_reg, res_next;

    logic [48:0] acc;

    always_comb
    begin
        w_next  = (cfg.core_weight > edgpsf_pkg::WeightOne) ? edgpsf_pkg::WeightOne
                                                            : cfg.core_weight;
        wc_next = edgpsf_pkg::WeightOne - w_reg;

        v1_next  = gauss.valid;
        in1_next = gauss.in_edge;
        pn_next  = 48'(gauss.gn) * 48'(w_reg);
        pw_next  = 48'(gauss.gw) * 48'(wc_reg);

        acc       = 49'(pn_reg) + 49'(pw_reg) + 49'd32768;
        done_next = v1_reg;
        res_next.inside_edge = in1_reg;
        if (!in1_reg)
        begin
            res_next.psf_value = '0;
        end
        else if (acc[48])
        begin
            res_next.psf_value = '1;
        end
        else
        begin
            res_next.psf_value = acc[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v1_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_reg   <= w_next;
        wc_reg  <= wc_next;
        in1_reg <= in1_next;
        pn_reg  <= pn_next;
        pw_reg  <= pw_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== src/elliptical_double_gaussian_psf_core.sv =====
// Top level of the elliptical double-Gaussian PSF core: configuration registers
// and the radius, Gaussian and mixing pipelines. Depends on edgpsf_pkg and all src modules.
//
// A start beat carries one offset (offset_x, offset_y) in signed Q8.8 and is taken at every
// rising edge where start is high; busy is never raised, so a new offset may be presented in
// every clock cycle and the core sustains one beat per cycle. The offset is rotated by the
// configured cosine and sine, the squared elliptical radius is formed with the axis ratio and
// its reciprocal, and inside the edge radius the core returns the weighted sum of a narrow and
// a wide normalised Gaussian, each read from an exp(-u) table of EXP_TABLE_DEPTH entries whose
// contents are fixed when the design is built. Outside the edge psf_value is zero and
// inside_edge is low. The result beat appears on result, marked by a one-cycle done strobe,
// after its start beat has passed through five register stages for the radius, four for the
// exponent argument, table address, table read and prefactor scaling, and two for weighting
// and saturation. Results leave in the order the offsets arrived and cannot be held off, so the
// receiver must take each beat in the cycle that done is high. The registers are written
// through wr_en, wr_index and wr_data with no wait state; they must only be changed while no
// offset is in flight, since the pipelines read them directly at several stages.
module elliptical_double_gaussian_psf_core
#(
    parameter int EXP_TABLE_DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  edgpsf_pkg::psf_in_t  item,
    input  logic                 wr_en,
    input  logic [2:0]           wr_index,
    input  logic [31:0]          wr_data,
    output logic                 done,
    output edgpsf_pkg::psf_out_t result
);

    edgpsf_pkg::psf_cfg_t    cfg_reg, cfg_next;
    edgpsf_pkg::rad_beat_t   rad;
    edgpsf_pkg::gauss_beat_t gauss;
    logic                    accept;

    // Every stage moves on each cycle, so the core is always ready for a beat.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Register writes: each register takes the low bits of the write data.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                edgpsf_pkg::CfgCosAngle:     cfg_next.cos_angle        = wr_data[15:0];
                edgpsf_pkg::CfgSinAngle:     cfg_next.sin_angle        = wr_data[15:0];
                edgpsf_pkg::CfgAxisRatio:    cfg_next.axis_ratio       = wr_data[15:0];
                edgpsf_pkg::CfgInvAxisRatio: cfg_next.inv_axis_ratio   = wr_data[15:0];
                edgpsf_pkg::CfgCoreWeight:   cfg_next.core_weight      = wr_data[16:0];
                edgpsf_pkg::CfgNarrowPrec:   cfg_next.narrow_precision = wr_data[23:0];
                edgpsf_pkg::CfgWidePrec:     cfg_next.wide_precision   = wr_data[23:0];
                edgpsf_pkg::CfgEdgeRadiusSq: cfg_next.edge_radius_sq   = wr_data[31:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cos_angle        <= edgpsf_pkg::RstCosAngle;
            cfg_reg.sin_angle        <= edgpsf_pkg::RstSinAngle;
            cfg_reg.axis_ratio       <= edgpsf_pkg::RstAxisRatio;
            cfg_reg.inv_axis_ratio   <= edgpsf_pkg::RstInvAxisRatio;
            cfg_reg.core_weight      <= edgpsf_pkg::RstCoreWeight;
            cfg_reg.narrow_precision <= edgpsf_pkg::RstNarrowPrec;
            cfg_reg.wide_precision   <= edgpsf_pkg::RstWidePrec;
            cfg_reg.edge_radius_sq   <= edgpsf_pkg::RstEdgeRadiusSq;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Rotation and squared radius, with the edge test at its end.
    edgpsf_radius u_radius (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .rad      (rad)
    );

    // Both Gaussian terms, sharing one two-port exp table.
    edgpsf_gauss #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_gauss (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .rad   (rad),
        .gauss (gauss)
    );

    // Weighting, rounding to Q8.24 and saturation into the result register.
    edgpsf_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .gauss  (gauss),
        .done   (done),
        .result (result)
    );

endmodule
